FILE: sv/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and codes for the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int unsigned TIME_W = 48;
    localparam int unsigned PER_W  = 32;
    localparam int unsigned ID_W   = 4;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [2:0] {
        FN_SCHED  = 3'd0,
        FN_CANCEL = 3'd1,
        FN_TICK   = 3'd2,
        FN_START  = 3'd3,
        FN_FINISH = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        ST_SCHED = 3'd0,
        ST_RUN   = 3'd1,
        ST_CANC  = 3'd2,
        ST_DONE  = 3'd3,
        ST_FREE  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ER_OK      = 3'd0,
        ER_FULL    = 3'd1,
        ER_FREE    = 3'd2,
        ER_ZERO    = 3'd3,
        ER_REFUSED = 3'd4
    } t_err;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_SCAN,
        S_HANDLE,
        S_OUT,
        S_CLOSE
    } t_fsm;

    // One candidate travelling down the search chain.
    typedef struct packed {
        logic              found;
        logic [7:0]        idx;
        logic [TIME_W-1:0] t;
    } t_cand;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic              sched_wr;
        logic              stat_wr;
        logic              fire_wr;
        logic              dequeue;
        logic [7:0]        sel;
        t_status           status;
        logic [TIME_W-1:0] fire;
        logic [PER_W-1:0]  period;
        logic              rep;
        logic              skip;
    } t_cmd;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

endpackage

FILE: sv/deadline_timer_queue.sv
// ----------------------------------------------------------------------------
// deadline_timer_queue
// Timer slot table with an earliest-deadline dispatch queue.
// ----------------------------------------------------------------------------
// Requests enter on i_valid/o_ready; results leave on o_valid/i_ready.
// Schedule, cancel, start and finish each give one result, held in the
// output register until taken. A tick gives one result per handled slot
// (at most MAX_DISPATCH), then a closing result with o_last high.
// Due slots are found by a search candidate that walks the chain of slot
// cells, one cell per cycle.
// A stalled receiver holds the result register; a running search goes on,
// but the block waits before it loads the next result.
// One request is in flight at a time;
// o_ready is low until its last result has been taken.
// Reset frees every slot, empties the queue and sets the time to zero.
// ----------------------------------------------------------------------------
module deadline_timer_queue
    import dtq_pkg::*;
#(
    parameter int unsigned SLOTS        = 16,
    parameter int unsigned MAX_DISPATCH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_func,
    input  logic [ID_W-1:0]   i_slot,
    input  logic [TIME_W-1:0] i_delay,
    input  logic [PER_W-1:0]  i_period,
    input  logic              i_repeating,
    input  logic              i_skip_overlap,
    input  logic [TIME_W-1:0] i_now_time,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ID_W-1:0]   o_slot_id,
    output logic [2:0]        o_slot_state,
    output logic              o_dispatched,
    output logic [2:0]        o_error,
    output logic              o_last
);

    localparam int unsigned CW = $clog2(SLOTS + 2);
    localparam int unsigned DW = $clog2(MAX_DISPATCH + 1);
    localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_fsm              r_state, n_state;
    logic [2:0]        r_func;
    logic [ID_W-1:0]   r_slot;
    logic [TIME_W-1:0] r_delay;
    logic [PER_W-1:0]  r_per;
    logic              r_rep, r_skip;
    logic [TIME_W-1:0] r_now;
    logic [CW-1:0]     r_cnt;
    logic [DW-1:0]     r_ndisp;
    logic [SW-1:0]     r_best;
    logic              r_ov;
    logic [ID_W-1:0]   r_oid;
    logic [2:0]        r_ost, r_oerr;
    logic              r_odisp, r_olast;

    t_cmd              w_cmd;
    t_cand             w_chain [SLOTS+1];
    logic              w_alloc [SLOTS+1];
    logic              w_free_v [SLOTS];
    t_status           w_status [SLOTS];
    logic [TIME_W-1:0] w_fire [SLOTS];
    logic [PER_W-1:0]  w_perv [SLOTS];
    logic              w_repv [SLOTS];
    logic              w_skipv [SLOTS];
    logic              w_scan;
    logic [SW-1:0]     w_first;
    logic              w_load;
    logic [ID_W-1:0]   n_oid;
    logic [2:0]        n_ost, n_oerr;
    logic              n_odisp, n_olast;

    assign w_chain[0] = '0;
    assign w_alloc[0] = 1'b0;
    assign w_scan = (r_state == S_SCAN);

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        dtq_cell #(.IDX(8'(g))) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (w_cmd),
            .i_now      (r_now),
            .i_scan     (w_scan),
            .i_alloc_in (w_alloc[g]),
            .o_alloc_out(w_alloc[g+1]),
            .i_cand     (w_chain[g]),
            .o_cand     (w_chain[g+1]),
            .o_status   (w_status[g]),
            .o_fire     (w_fire[g]),
            .o_period   (w_perv[g]),
            .o_rep      (w_repv[g]),
            .o_skip     (w_skipv[g])
        );
        assign w_free_v[g] = w_alloc[g+1] && !w_alloc[g];
    end

    always_comb begin
        w_first = '0;
        for (int k = 0; k < SLOTS; k++)
            if (w_free_v[k]) w_first = SW'(k);
    end

    assign o_ready      = (r_state == S_IDLE) && !r_ov;
    assign o_valid      = r_ov;
    assign o_slot_id    = r_oid;
    assign o_slot_state = r_ost;
    assign o_dispatched = r_odisp;
    assign o_error      = r_oerr;
    assign o_last       = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_cnt   <= '0;
            r_ndisp <= '0;
            r_now   <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_ov    <= 1'b1;
                r_oid   <= n_oid;
                r_ost   <= n_ost;
                r_odisp <= n_odisp;
                r_oerr  <= n_oerr;
                r_olast <= n_olast;
            end else if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            if (i_valid && o_ready) begin
                r_func  <= i_func;
                r_slot  <= i_slot;
                r_delay <= i_delay;
                r_per   <= i_period;
                r_rep   <= i_repeating;
                r_skip  <= i_skip_overlap;
                r_ndisp <= '0;
                if (i_func == FN_TICK) r_now <= i_now_time;
            end
            if (r_state == S_SCAN) r_cnt <= r_cnt + 1'b1;
            else r_cnt <= '0;
            if (r_state == S_HANDLE) begin
                r_best  <= SW'(w_chain[SLOTS].idx);
                r_ndisp <= r_ndisp + 1'b1;
            end
        end
    end

    always_comb begin
        t_status st;
        logic    busy;
        n_state = r_state;
        w_cmd   = '0;
        w_cmd.status = ST_FREE;
        w_load  = 1'b0;
        n_oid   = '0;
        n_ost   = ST_FREE;
        n_odisp = 1'b0;
        n_oerr  = ER_OK;
        n_olast = 1'b1;
        busy    = r_ov && !i_ready;
        st      = ST_FREE;
        case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) n_state = S_ALLOC;
            end
            S_ALLOC: begin
                if (!busy) begin
                    case (r_func)
                        FN_TICK: begin
                            n_state = S_SCAN;
                        end
                        FN_SCHED: begin
                            w_load  = 1'b1;
                            n_state = S_IDLE;
                            if (r_rep && r_per == '0) begin
                                n_oerr = ER_ZERO;
                            end else if (!w_alloc[SLOTS]) begin
                                n_oerr = ER_FULL;
                            end else begin
                                w_cmd.sched_wr = 1'b1;
                                w_cmd.sel      = 8'(w_first);
                                w_cmd.fire     = sat_add(r_now, r_delay);
                                w_cmd.period   = r_per;
                                w_cmd.rep      = r_rep;
                                w_cmd.skip     = r_skip;
                                n_oid = ID_W'(w_first);
                                n_ost = ST_SCHED;
                            end
                        end
                        FN_CANCEL, FN_START, FN_FINISH: begin
                            w_load  = 1'b1;
                            n_state = S_IDLE;
                            n_oid   = r_slot;
                            if (32'(r_slot) >= SLOTS ||
                                w_status[SW'(r_slot)] == ST_FREE) begin
                                n_oerr = ER_FREE;
                            end else begin
                                st = w_status[SW'(r_slot)];
                                n_oerr = ER_REFUSED;
                                if (r_func == FN_CANCEL &&
                                    (st == ST_SCHED || st == ST_RUN)) begin
                                    st = ST_CANC;
                                    n_oerr = ER_OK;
                                end else if (r_func == FN_START && st == ST_SCHED) begin
                                    st = ST_RUN;
                                    n_oerr = ER_OK;
                                end else if (r_func == FN_FINISH && st == ST_RUN) begin
                                    st = w_repv[SW'(r_slot)] ? ST_SCHED : ST_DONE;
                                    n_oerr = ER_OK;
                                end
                                w_cmd.stat_wr = 1'b1;
                                w_cmd.sel     = 8'(r_slot);
                                w_cmd.status  = st;
                                n_ost = st;
                            end
                        end
                        default: begin
                            w_load  = 1'b1;
                            n_state = S_IDLE;
                            n_oerr  = ER_REFUSED;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Stay here until the candidate has reached the chain's end.
                if (r_cnt == CW'(SLOTS)) n_state = S_HANDLE;
            end
            S_HANDLE: begin
                if (!w_chain[SLOTS].found || 32'(r_ndisp) >= MAX_DISPATCH)
                    n_state = S_CLOSE;
                else
                    n_state = S_OUT;
            end
            S_OUT: begin
                if (!busy) begin
                    w_load  = 1'b1;
                    n_olast = 1'b0;
                    n_oid   = ID_W'(r_best);
                    st      = w_status[r_best];
                    n_ost   = st;
                    w_cmd.sel = 8'(r_best);
                    if (st == ST_CANC) begin
                        w_cmd.dequeue = 1'b1;
                    end else if (w_repv[r_best]) begin
                        w_cmd.fire_wr = 1'b1;
                        w_cmd.fire = sat_add(w_fire[r_best],
                                             {{(TIME_W-PER_W){1'b0}}, w_perv[r_best]});
                        n_odisp = !(w_skipv[r_best] && st == ST_RUN);
                    end else begin
                        w_cmd.dequeue = 1'b1;
                        n_odisp = 1'b1;
                    end
                    n_state = S_SCAN;
                end
            end
            S_CLOSE: begin
                if (!busy) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: sv/dtq_cell.sv
// ----------------------------------------------------------------------------
// dtq_cell
// One timer slot: holds its state and passes a search candidate onward.
// ----------------------------------------------------------------------------
module dtq_cell
    import dtq_pkg::*;
#(
    parameter logic [7:0] IDX = 8'd0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [TIME_W-1:0] i_now,
    input  logic              i_scan,
    input  logic              i_alloc_in,
    output logic              o_alloc_out,
    input  t_cand             i_cand,
    output t_cand             o_cand,
    output t_status           o_status,
    output logic [TIME_W-1:0] o_fire,
    output logic [PER_W-1:0]  o_period,
    output logic              o_rep,
    output logic              o_skip
);

    t_status           r_status;
    logic              r_queued;
    logic [TIME_W-1:0] r_fire;
    logic [PER_W-1:0]  r_period;
    logic              r_rep;
    logic              r_skip;
    t_cand             r_cand;
    logic              w_hit;
    logic              w_free;

    assign w_hit = i_cmd.sel == IDX;
    // Lowest allocatable slot: the first cell in the chain that is free.
    assign w_free = (r_status == ST_FREE) ||
                    ((r_status == ST_CANC || r_status == ST_DONE) && !r_queued);
    assign o_alloc_out = i_alloc_in || w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= ST_FREE;
            r_queued <= 1'b0;
        end else begin
            if (w_hit && i_cmd.sched_wr) begin
                r_status <= ST_SCHED;
                r_queued <= 1'b1;
                r_fire   <= i_cmd.fire;
                r_period <= i_cmd.period;
                r_rep    <= i_cmd.rep;
                r_skip   <= i_cmd.skip;
            end
            if (w_hit && i_cmd.stat_wr) r_status <= i_cmd.status;
            if (w_hit && i_cmd.fire_wr) r_fire <= i_cmd.fire;
            if (w_hit && i_cmd.dequeue) r_queued <= 1'b0;
        end
    end

    // Strict less-than keeps the earlier (lower) slot on a tie.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand.found <= 1'b0;
        end else if (i_scan) begin
            if (r_queued && r_fire <= i_now && (!i_cand.found || r_fire < i_cand.t)) begin
                r_cand.found <= 1'b1;
                r_cand.idx   <= IDX;
                r_cand.t     <= r_fire;
            end else begin
                r_cand <= i_cand;
            end
        end
    end

    assign o_cand   = r_cand;
    assign o_status = r_status;
    assign o_fire   = r_fire;
    assign o_period = r_period;
    assign o_rep    = r_rep;
    assign o_skip   = r_skip;

endmodule

FILE: sv/dtq_checker.sv
// ----------------------------------------------------------------------------
// dtq_checker
// Port-level checks on the deadline timer queue.
// ----------------------------------------------------------------------------
module dtq_checker
    import dtq_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [3:0] o_slot_id,
    input logic [2:0] o_slot_state,
    input logic       o_dispatched,
    input logic [2:0] o_error,
    input logic       o_last
);

    // No new request is taken while a result is still waiting.
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while result pending");

    // A held result stays valid and keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_slot_id) &&
        $stable(o_slot_state) && $stable(o_dispatched) &&
        $stable(o_error) && $stable(o_last))
        else $error("result changed while stalled");

    // A waiting request stays offered until it is taken.
    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid)
        else $error("request withdrawn before accept");

    // Only intermediate tick results may dispatch, and they carry no error.
    a_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dispatched |-> !o_last && o_error == ER_OK)
        else $error("bad dispatch result");

    // An error result always closes the request.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error != ER_OK |-> o_last)
        else $error("error result without last");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_slot_id   (o_slot_id),
    .o_slot_state(o_slot_state),
    .o_dispatched(o_dispatched),
    .o_error     (o_error),
    .o_last      (o_last)
);
